>>> rtl/bmma_pkg.sv
// ----------------------------------------------------------------------------
// bmma_pkg
// Shared types, codes and defaults of the block multiply-accumulate core.
// ----------------------------------------------------------------------------
package bmma_pkg;

    localparam int DEF_MAX_ROWS  = 16;
    localparam int DEF_MAX_COLS  = 16;
    localparam int DEF_MAX_INNER = 16;

    localparam int CMD_W   = 3;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 32;
    localparam int DIM_W   = 5;
    localparam int REG_IDX_W = 2;
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_C = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MAC    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_C = 3'd4;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INNER = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
        logic rd_c;
        logic mac_issue;
        logic mac_first;
        logic mac_last;
        logic out_mult;
        logic out_read;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/bmma_ram.sv
// ----------------------------------------------------------------------------
// bmma_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bmma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bmma_ctrl.sv
// ----------------------------------------------------------------------------
// bmma_ctrl
// Command sequencer: configuration registers, request decode and the
// row/column/inner walk of the multiply.
// ----------------------------------------------------------------------------
module bmma_ctrl #(
    parameter int MAX_ROWS  = bmma_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = bmma_pkg::DEF_MAX_COLS,
    parameter int MAX_INNER = bmma_pkg::DEF_MAX_INNER,
    parameter int RW  = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1,
    parameter int CW  = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1,
    parameter int KW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmma_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [bmma_pkg::DIM_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bmma_pkg::CMD_W-1:0]        cmd,
    input  bmma_pkg::dp_status_t              status,
    output bmma_pkg::ctrl_cmd_t               ctrl,
    output logic [RW-1:0]                     mac_i,
    output logic [CW-1:0]                     mac_j,
    output logic [KW-1:0]                     mac_k
);

    localparam int NRW = $clog2(MAX_ROWS + 1);
    localparam int NCW = $clog2(MAX_COLS + 1);
    localparam int NKW = $clog2(MAX_INNER + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [bmma_pkg::DIM_W-1:0] rows_reg, cols_reg, inner_reg;
    logic [RW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [KW-1:0] k_reg, k_next;
    logic [NRW-1:0] nr;
    logic [NCW-1:0] nc;
    logic [NKW-1:0] nk;
    logic accept, last_i, last_j, last_k, empty;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;

    assign nr = (32'(rows_reg)  > MAX_ROWS)  ? NRW'(MAX_ROWS)  : NRW'(rows_reg);
    assign nc = (32'(cols_reg)  > MAX_COLS)  ? NCW'(MAX_COLS)  : NCW'(cols_reg);
    assign nk = (32'(inner_reg) > MAX_INNER) ? NKW'(MAX_INNER) : NKW'(inner_reg);
    assign empty = (nr == '0) || (nc == '0) || (nk == '0);

    assign last_i = (NRW'(i_reg) + NRW'(1)) == nr;
    assign last_j = (NCW'(j_reg) + NCW'(1)) == nc;
    assign last_k = (NKW'(k_reg) + NKW'(1)) == nk;

    assign mac_i = i_reg;
    assign mac_j = j_reg;
    assign mac_k = k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= bmma_pkg::DIM_RESET;
            cols_reg  <= bmma_pkg::DIM_RESET;
            inner_reg <= bmma_pkg::DIM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bmma_pkg::REG_ROWS:  rows_reg  <= cfg_data;
                bmma_pkg::REG_COLS:  cols_reg  <= cfg_data;
                bmma_pkg::REG_INNER: inner_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        bmma_pkg::CMD_LOAD_A: ctrl.load_a = 1'b1;
                        bmma_pkg::CMD_LOAD_B: ctrl.load_b = 1'b1;
                        bmma_pkg::CMD_LOAD_C: ctrl.load_c = 1'b1;
                        bmma_pkg::CMD_MAC:
                        begin
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                            state_next = empty ? ST_DONE : ST_MAC;
                        end
                        bmma_pkg::CMD_READ_C:
                        begin
                            ctrl.rd_c  = 1'b1;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (status.out_free)
                begin
                    ctrl.out_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                ctrl.mac_issue = 1'b1;
                ctrl.mac_first = (k_reg == '0);
                ctrl.mac_last  = last_k;
                if (!last_k)
                begin
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    k_next = '0;
                    if (!last_j)
                    begin
                        j_next = j_reg + CW'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        if (!last_i)
                        begin
                            i_next = i_reg + RW'(1);
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.out_mult = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

>>> rtl/bmma_datapath.sv
// ----------------------------------------------------------------------------
// bmma_datapath
// Matrix stores, MAC pipeline, saturating write-back and result register.
// ----------------------------------------------------------------------------
module bmma_datapath #(
    parameter int MAX_ROWS  = bmma_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = bmma_pkg::DEF_MAX_COLS,
    parameter int MAX_INNER = bmma_pkg::DEF_MAX_INNER,
    parameter int RW  = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1,
    parameter int CW  = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1,
    parameter int KW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bmma_pkg::ctrl_cmd_t               ctrl,
    output bmma_pkg::dp_status_t              status,
    input  logic [RW-1:0]                     mac_i,
    input  logic [CW-1:0]                     mac_j,
    input  logic [KW-1:0]                     mac_k,
    input  logic [bmma_pkg::IDX_W-1:0]        row_index,
    input  logic [bmma_pkg::IDX_W-1:0]        col_index,
    input  logic signed [bmma_pkg::DATA_W-1:0] elem_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              result_kind,
    output logic signed [bmma_pkg::DATA_W-1:0] c_value,
    output logic                              saturated
);

    localparam int DW    = bmma_pkg::DATA_W;
    localparam int AD    = MAX_ROWS * MAX_INNER;
    localparam int BD    = MAX_INNER * MAX_COLS;
    localparam int CD    = MAX_ROWS * MAX_COLS;
    localparam int AAW   = (AD > 1) ? $clog2(AD) : 1;
    localparam int BAW   = (BD > 1) ? $clog2(BD) : 1;
    localparam int CAW   = (CD > 1) ? $clog2(CD) : 1;
    localparam logic signed [bmma_pkg::ACC_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [bmma_pkg::ACC_W-1:0] SAT_LO = -64'sh0000_0000_8000_0000;

    logic [31:0] row_w, col_w;
    logic a_ok, b_ok, c_ok;
    logic [AAW-1:0] a_ld_addr, a_mac_addr;
    logic [BAW-1:0] b_ld_addr, b_mac_addr;
    logic [CAW-1:0] c_ld_addr, c_mac_addr, c_raddr, c_waddr;
    logic [DW-1:0] a_rdata, b_rdata, c_rdata, c_wdata;
    logic c_we, c_re;

    logic s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [CAW-1:0] s1_addr_reg;
    logic s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [CAW-1:0] s2_addr_reg;
    logic signed [bmma_pkg::ACC_W-1:0] s2_prod_reg, s2_c_reg, prod_full;
    logic signed [bmma_pkg::ACC_W-1:0] prod_raw;
    logic wb_valid_reg;
    logic [CAW-1:0] wb_addr_reg;
    logic signed [bmma_pkg::ACC_W-1:0] acc_reg;
    logic rd_ok_reg, sat_flag_reg, sat_hit;
    logic [DW-1:0] sat_value;

    logic out_valid_reg, kind_reg, saturated_reg;
    logic [DW-1:0] c_value_reg;

    assign row_w = 32'(row_index);
    assign col_w = 32'(col_index);
    assign a_ok  = (row_w < MAX_ROWS)  && (col_w < MAX_INNER);
    assign b_ok  = (row_w < MAX_INNER) && (col_w < MAX_COLS);
    assign c_ok  = (row_w < MAX_ROWS)  && (col_w < MAX_COLS);

    assign a_ld_addr  = AAW'(row_w * MAX_INNER + col_w);
    assign b_ld_addr  = BAW'(row_w * MAX_COLS + col_w);
    assign c_ld_addr  = CAW'(row_w * MAX_COLS + col_w);
    assign a_mac_addr = AAW'(32'(mac_i) * MAX_INNER + 32'(mac_k));
    assign b_mac_addr = BAW'(32'(mac_k) * MAX_COLS + 32'(mac_j));
    assign c_mac_addr = CAW'(32'(mac_i) * MAX_COLS + 32'(mac_j));

    assign c_re    = ctrl.rd_c || (ctrl.mac_issue && ctrl.mac_first);
    assign c_raddr = ctrl.mac_issue ? c_mac_addr : c_ld_addr;
    assign c_we    = (ctrl.load_c && c_ok) || wb_valid_reg;
    assign c_waddr = wb_valid_reg ? wb_addr_reg : c_ld_addr;
    assign c_wdata = wb_valid_reg ? sat_value : elem_value;

    bmma_ram #(.WIDTH(DW), .DEPTH(AD)) u_a_ram (
        .clk   (clk),
        .we    (ctrl.load_a && a_ok),
        .waddr (a_ld_addr),
        .wdata (elem_value),
        .re    (ctrl.mac_issue),
        .raddr (a_mac_addr),
        .rdata (a_rdata)
    );

    bmma_ram #(.WIDTH(DW), .DEPTH(BD)) u_b_ram (
        .clk   (clk),
        .we    (ctrl.load_b && b_ok),
        .waddr (b_ld_addr),
        .wdata (elem_value),
        .re    (ctrl.mac_issue),
        .raddr (b_mac_addr),
        .rdata (b_rdata)
    );

    bmma_ram #(.WIDTH(DW), .DEPTH(CD)) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    assign prod_raw  = $signed(a_rdata) * $signed(b_rdata);
    assign prod_full = prod_raw >>> bmma_pkg::FRAC_W;

    assign sat_hit   = (acc_reg > SAT_HI) || (acc_reg < SAT_LO);
    assign sat_value = (acc_reg > SAT_HI) ? SAT_HI[DW-1:0] :
                       (acc_reg < SAT_LO) ? SAT_LO[DW-1:0] : acc_reg[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            sat_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.mac_issue;
            s2_valid_reg <= s1_valid_reg;
            wb_valid_reg <= s2_valid_reg && s2_last_reg;
            priority if (ctrl.load_c)
            begin
                sat_flag_reg <= 1'b0;
            end
            else if (wb_valid_reg && sat_hit)
            begin
                sat_flag_reg <= 1'b1;
            end
            priority if (ctrl.out_mult || ctrl.out_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= ctrl.mac_first;
        s1_last_reg  <= ctrl.mac_last;
        s1_addr_reg  <= c_mac_addr;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_addr_reg  <= s1_addr_reg;
        s2_prod_reg  <= prod_full;
        if (s1_first_reg)
        begin
            s2_c_reg <= bmma_pkg::ACC_W'($signed(c_rdata));
        end
        if (s2_valid_reg)
        begin
            acc_reg <= s2_first_reg ? (s2_c_reg + s2_prod_reg) : (acc_reg + s2_prod_reg);
        end
        wb_addr_reg <= s2_addr_reg;
        if (ctrl.rd_c)
        begin
            rd_ok_reg <= c_ok;
        end
        if (ctrl.out_mult)
        begin
            kind_reg      <= bmma_pkg::KIND_DONE;
            c_value_reg   <= '0;
            saturated_reg <= sat_flag_reg;
        end
        else if (ctrl.out_read)
        begin
            kind_reg      <= bmma_pkg::KIND_READ;
            c_value_reg   <= rd_ok_reg ? c_rdata : '0;
            saturated_reg <= sat_flag_reg;
        end
    end

    assign status.pipe_busy = s1_valid_reg || s2_valid_reg || wb_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign c_value     = c_value_reg;
    assign saturated   = saturated_reg;

    a_wb_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> !(ctrl.load_c || ctrl.load_a || ctrl.load_b))
        else $error("write-back overlaps a load");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.out_mult || ctrl.out_read) |-> status.out_free)
        else $error("result loaded over a pending result");

    a_mult_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_mult |-> !status.pipe_busy)
        else $error("multiply reported before pipeline drained");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.out_mult && ctrl.out_read))
        else $error("two results at once");

endmodule

>>> rtl/block_matrix_multiply_accumulate_core.sv
// ----------------------------------------------------------------------------
// block_matrix_multiply_accumulate_core
// C += A*B engine on signed Q16.16 values with saturating write-back.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       to core    in_valid / in_stall    cmd, row_index, col_index, elem_value
// out      from core  out_valid / out_stall  result_kind, c_value, saturated
// cfg      to core    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load is written into its store as it is accepted; a read of C goes through
// the registered RAM read and then the result register. A multiply issues one
// MAC a cycle through the A/B RAM read ports, drains through read, multiply,
// accumulate and write-back, and then loads the result register.
// No request is accepted until the running one has handed over its result.
// Reset (rst_n, asynchronous) clears control state; store contents stay undefined.
// ----------------------------------------------------------------------------
module block_matrix_multiply_accumulate_core #(
    parameter int MAX_ROWS  = bmma_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = bmma_pkg::DEF_MAX_COLS,
    parameter int MAX_INNER = bmma_pkg::DEF_MAX_INNER
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmma_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [bmma_pkg::DIM_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bmma_pkg::CMD_W-1:0]         cmd,
    input  logic [bmma_pkg::IDX_W-1:0]         row_index,
    input  logic [bmma_pkg::IDX_W-1:0]         col_index,
    input  logic signed [bmma_pkg::DATA_W-1:0] elem_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               result_kind,
    output logic signed [bmma_pkg::DATA_W-1:0] c_value,
    output logic                               saturated
);

    localparam int RW = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1;
    localparam int CW = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1;
    localparam int KW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    bmma_pkg::ctrl_cmd_t  ctrl;
    bmma_pkg::dp_status_t status;
    logic [RW-1:0] mac_i;
    logic [CW-1:0] mac_j;
    logic [KW-1:0] mac_k;

    bmma_ctrl #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_INNER(MAX_INNER),
        .RW(RW), .CW(CW), .KW(KW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .status    (status),
        .ctrl      (ctrl),
        .mac_i     (mac_i),
        .mac_j     (mac_j),
        .mac_k     (mac_k)
    );

    bmma_datapath #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_INNER(MAX_INNER),
        .RW(RW), .CW(CW), .KW(KW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .mac_i       (mac_i),
        .mac_j       (mac_j),
        .mac_k       (mac_k),
        .row_index   (row_index),
        .col_index   (col_index),
        .elem_value  (elem_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .c_value     (c_value),
        .saturated   (saturated)
    );

endmodule

>>> verif/bmma_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmma_result_checker
// Watches the request, result and register channels of the multiply-accumulate
// core, keeps its own copy of the A, B and C stores and the dimension
// registers, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module bmma_result_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [bmma_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [bmma_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [bmma_pkg::CMD_W-1:0]           cmd,
    input  logic [bmma_pkg::IDX_W-1:0]           row_index,
    input  logic [bmma_pkg::IDX_W-1:0]           col_index,
    input  logic signed [bmma_pkg::DATA_W-1:0]   elem_value,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 result_kind,
    input  logic signed [bmma_pkg::DATA_W-1:0]   c_value,
    input  logic                                 saturated,
    output int                                   fail_count,
    output int                                   pending
);

    localparam int DW  = bmma_pkg::DATA_W;
    localparam int NR  = bmma_pkg::DEF_MAX_ROWS;
    localparam int NC  = bmma_pkg::DEF_MAX_COLS;
    localparam int NK  = bmma_pkg::DEF_MAX_INNER;

    typedef struct {
        logic          kind;
        logic [DW-1:0] value;
        logic          sat;
    } c_result_t;

    c_result_t                      expected_results[$];
    logic [DW-1:0]                  a_mem [NR*NK];
    logic [DW-1:0]                  b_mem [NK*NC];
    logic [DW-1:0]                  c_mem [NR*NC];
    logic [bmma_pkg::DIM_W-1:0]     rows_used;
    logic [bmma_pkg::DIM_W-1:0]     cols_used;
    logic [bmma_pkg::DIM_W-1:0]     inner_used;
    logic                           sat_flag;

    function automatic int clamp_dim(logic [bmma_pkg::DIM_W-1:0] v, int maxv);
        return (v > maxv) ? maxv : int'(v);
    endfunction

    task automatic accumulate_block();
        int     nr;
        int     nc;
        int     nk;
        longint acc;
        longint prod;
        nr = clamp_dim(rows_used, NR);
        nc = clamp_dim(cols_used, NC);
        nk = clamp_dim(inner_used, NK);
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                acc = longint'($signed(c_mem[i*NC+j]));
                for (int k = 0; k < nk; k++)
                begin
                    prod = longint'($signed(a_mem[i*NK+k]))
                         * longint'($signed(b_mem[k*NC+j]));
                    acc += prod >>> bmma_pkg::FRAC_W;
                end
                if (acc > 64'sh7FFF_FFFF)
                begin
                    acc = 64'sh7FFF_FFFF;
                    sat_flag = 1'b1;
                end
                else if (acc < -64'sh8000_0000)
                begin
                    acc = -64'sh8000_0000;
                    sat_flag = 1'b1;
                end
                c_mem[i*NC+j] = acc[DW-1:0];
            end
        end
    endtask

    task automatic apply_request();
        c_result_t res;
        case (cmd)
            bmma_pkg::CMD_LOAD_A: a_mem[row_index*NK+col_index] = elem_value;
            bmma_pkg::CMD_LOAD_B: b_mem[row_index*NC+col_index] = elem_value;
            bmma_pkg::CMD_LOAD_C:
            begin
                sat_flag = 1'b0;
                c_mem[row_index*NC+col_index] = elem_value;
            end
            bmma_pkg::CMD_MAC:
            begin
                accumulate_block();
                res.kind = bmma_pkg::KIND_DONE;
                res.value = '0;
                res.sat = sat_flag;
                expected_results.push_back(res);
            end
            bmma_pkg::CMD_READ_C:
            begin
                res.kind = bmma_pkg::KIND_READ;
                res.value = c_mem[row_index*NC+col_index];
                res.sat = sat_flag;
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic compare_result();
        c_result_t exp_res;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: kind %0d value %h", result_kind, c_value);
            fail_count++;
            return;
        end
        exp_res = expected_results.pop_front();
        if (result_kind !== exp_res.kind)
        begin
            $error("result_kind: expected %0d actual %0d", exp_res.kind, result_kind);
            fail_count++;
        end
        if (c_value !== exp_res.value)
        begin
            $error("c_value: expected %h actual %h", exp_res.value, c_value);
            fail_count++;
        end
        if (saturated !== exp_res.sat)
        begin
            $error("saturated: expected %0d actual %0d", exp_res.sat, saturated);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used = bmma_pkg::DIM_RESET;
            cols_used = bmma_pkg::DIM_RESET;
            inner_used = bmma_pkg::DIM_RESET;
            sat_flag = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_result();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bmma_pkg::REG_ROWS:  rows_used = cfg_data;
                    bmma_pkg::REG_COLS:  cols_used = cfg_data;
                    bmma_pkg::REG_INNER: inner_used = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                apply_request();
        end
        pending = expected_results.size();
    end

endmodule

>>> verif/block_matrix_multiply_accumulate_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_matrix_multiply_accumulate_core_test
// Fills the A, B and C stores, then drives directed and random load, multiply
// and read requests through several dimension settings and idling mixes,
// while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module block_matrix_multiply_accumulate_core_test;

    localparam int IW    = bmma_pkg::IDX_W;
    localparam int DW    = bmma_pkg::DATA_W;
    localparam int DIMW  = bmma_pkg::DIM_W;
    localparam int CMDW  = bmma_pkg::CMD_W;
    localparam int REGW  = bmma_pkg::REG_IDX_W;

    localparam int               CYCLE_LIMIT = 1000000;
    localparam logic [REGW-1:0]  REG_SPARE = 2'd3;
    localparam logic [CMDW-1:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMDW-1:0]  CMD_SPARE_MID = 3'd6;
    localparam logic [CMDW-1:0]  CMD_SPARE_LAST = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [REGW-1:0]          cfg_index = '0;
    logic [DIMW-1:0]          cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [CMDW-1:0]          cmd = '0;
    logic [IW-1:0]            row_index = '0;
    logic [IW-1:0]            col_index = '0;
    logic signed [DW-1:0]     elem_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     result_kind;
    logic signed [DW-1:0]     c_value;
    logic                     saturated;
    int                       fail_count;
    int                       pending;
    int                       idle_pct = 0;
    int                       stall_pct = 0;
    logic                     hold_off = 1'b0;
    int                       cycles = 0;
    event                     start_hold;

    block_matrix_multiply_accumulate_core dut (.*);

    bmma_result_checker u_checker (.*);

    always #5 clk = ~clk;

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    initial
    begin
        forever
        begin
            @(start_hold);
            hold_off = 1'b1;
            repeat (400) @(negedge clk);
            hold_off = 1'b0;
        end
    end

    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $signed($urandom) >>> 8;
        endcase
    endfunction

    task automatic send_request(logic [CMDW-1:0] c, logic [IW-1:0] r,
                                logic [IW-1:0] k, logic [DW-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        row_index <= r;
        col_index <= k;
        elem_value <= v;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [REGW-1:0] idx, logic [DIMW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_dims(logic [DIMW-1:0] r, logic [DIMW-1:0] c,
                            logic [DIMW-1:0] k);
        wait_drained();
        write_reg(bmma_pkg::REG_ROWS, r);
        write_reg(bmma_pkg::REG_COLS, c);
        write_reg(bmma_pkg::REG_INNER, k);
    endtask

    task automatic set_random_dims();
        set_dims(DIMW'($urandom_range(1, 4)), DIMW'($urandom_range(1, 4)),
                 DIMW'($urandom_range(1, 4)));
    endtask

    task automatic send_random(int count);
        int              sel;
        logic [IW-1:0]   r;
        logic [IW-1:0]   k;
        logic [CMDW-1:0] spare;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            r = IW'($urandom);
            k = IW'($urandom);
            spare = CMDW'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            if (sel < 10)
                send_request(bmma_pkg::CMD_LOAD_A, r, k, pick_value());
            else if (sel < 20)
                send_request(bmma_pkg::CMD_LOAD_B, r, k, pick_value());
            else if (sel < 32)
                send_request(bmma_pkg::CMD_LOAD_C, r, k, pick_value());
            else if (sel < 40)
                send_request(bmma_pkg::CMD_MAC, r, k, $urandom);
            else if (sel < 96)
                send_request(bmma_pkg::CMD_READ_C, r, k, $urandom);
            else
                send_request(spare, r, k, $urandom);
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < 16; r++)
        begin
            for (int k = 0; k < 16; k++)
            begin
                send_request(bmma_pkg::CMD_LOAD_A, IW'(r), IW'(k), pick_value());
                send_request(bmma_pkg::CMD_LOAD_B, IW'(r), IW'(k), pick_value());
                send_request(bmma_pkg::CMD_LOAD_C, IW'(r), IW'(k), pick_value());
            end
        end

        send_request(bmma_pkg::CMD_READ_C, 4'd0, 4'd0, 32'd0);
        send_request(bmma_pkg::CMD_READ_C, 4'd15, 4'd15, 32'd0);
        send_request(bmma_pkg::CMD_MAC, 4'd0, 4'd0, 32'd0);
        send_request(bmma_pkg::CMD_READ_C, 4'd0, 4'd0, 32'd0);
        send_request(bmma_pkg::CMD_READ_C, 4'd15, 4'd0, 32'd0);
        send_request(bmma_pkg::CMD_READ_C, 4'd0, 4'd15, 32'd0);
        send_request(CMD_SPARE_FIRST, 4'd1, 4'd2, 32'h7FFF_FFFF);
        send_request(CMD_SPARE_MID, 4'd3, 4'd4, 32'h8000_0000);
        send_request(CMD_SPARE_LAST, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_request(bmma_pkg::CMD_LOAD_C, 4'd3, 4'd4, 32'h8000_0000);
        send_request(bmma_pkg::CMD_READ_C, 4'd3, 4'd4, 32'd0);
        send_request(bmma_pkg::CMD_LOAD_A, 4'd15, 4'd15, 32'h7FFF_FFFF);
        send_request(bmma_pkg::CMD_LOAD_B, 4'd15, 4'd15, 32'h7FFF_FFFF);

        set_dims(5'd0, 5'd5, 5'd5);
        send_request(bmma_pkg::CMD_MAC, 4'd0, 4'd0, 32'd0);
        send_request(bmma_pkg::CMD_READ_C, 4'd0, 4'd0, 32'd0);
        set_dims(5'd31, 5'd31, 5'd31);
        write_reg(REG_SPARE, 5'd31);
        send_request(bmma_pkg::CMD_MAC, 4'd0, 4'd0, 32'd0);
        send_request(bmma_pkg::CMD_READ_C, 4'd15, 4'd15, 32'd0);
        set_dims(5'd3, 5'd0, 5'd2);
        send_request(bmma_pkg::CMD_MAC, 4'd0, 4'd0, 32'd0);
        set_dims(5'd2, 5'd2, 5'd0);
        send_request(bmma_pkg::CMD_MAC, 4'd0, 4'd0, 32'd0);
        send_request(bmma_pkg::CMD_READ_C, 4'd1, 4'd1, 32'd0);

        set_dims(5'd1, 5'd16, 5'd1);
        send_random(220);

        set_random_dims();
        idle_pct = 61;
        send_random(220);

        set_dims(5'd4, 5'd3, 5'd2);
        idle_pct = 0;
        stall_pct = 61;
        ->start_hold;
        send_random(220);

        set_random_dims();
        idle_pct = 32;
        stall_pct = 32;
        send_random(220);

        stall_pct = 0;
        wait_drained();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> block_matrix_multiply_accumulate_core.f
rtl/bmma_pkg.sv
rtl/bmma_ram.sv
rtl/bmma_ctrl.sv
rtl/bmma_datapath.sv
rtl/block_matrix_multiply_accumulate_core.sv
verif/bmma_result_checker.sv
verif/block_matrix_multiply_accumulate_core_test.sv
